// ----- rtl/lfu_cache_with_protected_entry_top_macros.svh -----
// Assertion macros for the LFU surface cache.
`ifndef LFU_CACHE_WITH_PROTECTED_ENTRY_TOP_MACROS_SVH
`define LFU_CACHE_WITH_PROTECTED_ENTRY_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LCPE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LCPE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LCPE_ASSERT_NOW(lbl, ante, cons)
`define LCPE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/lcpe_pkg.sv -----
package lcpe_pkg;

   localparam int unsigned TAG_W = 16;
   localparam int unsigned HITS_W = 15;
   localparam int unsigned SLOT_W = 3;

   localparam logic [HITS_W-1:0] HIT_LIMIT = 15'd32000;
   localparam logic [HITS_W-1:0] HIT_MAX = 15'd32767;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic operation;
      logic [TAG_W-1:0] requested_surface;
      logic [TAG_W-1:0] protected_surface;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [SLOT_W-1:0] slot_used;
      logic evicted_valid;
      logic [TAG_W-1:0] evicted_surface;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [HITS_W-1:0] hits;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic empty_found;
   } scan_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/lfu_cache_with_protected_entry_top.sv -----
// Fully associative cache of surface ids with least-frequently-used eviction.
// A request arrives on the req_ channel and is taken when req_valid is high and
// req_stall is low. A lookup either hits, which bumps that slot's saturating
// counter, or misses and is inserted into the first empty slot. When the cache
// is full, the unprotected entry with the lowest count below 32000 is evicted
// first, or slot 0 if no entry qualifies. A clear request empties the cache.
// Each request gives exactly one response on the rsp_ channel.
// A lookup has the compare unit walk the single entry store read port one slot
// per cycle before the response is loaded; a clear skips the walk. req_stall
// is high while a request is in progress, so one request is handled at a time.
// The response sits in an output register; a new request may be taken while it
// waits, and the next one is held back until rsp_stall drops.
// Reset empties the cache at once and drops any pending response.
`include "lfu_cache_with_protected_entry_top_macros.svh"

module lfu_cache_with_protected_entry_top #(
   parameter int unsigned ENTRIES = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  lcpe_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output lcpe_pkg::rsp_type rsp_data
);
   import lcpe_pkg::*;

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   req_type req_ff;
   rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic accept;
   logic start;
   logic issue;
   logic update;
   logic load;

   entry_type rd_data;
   entry_type wr_data;
   logic [IDX_W-1:0] wr_addr;
   logic [HITS_W-1:0] hits_next;

   scan_flags_type scan_flags;
   logic [IDX_W-1:0] hit_idx;
   logic [HITS_W-1:0] hit_cnt;
   logic [IDX_W-1:0] empty_idx;
   logic [IDX_W-1:0] victim_idx;
   logic [TAG_W-1:0] victim_tag;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.operation == OP_CLEAR) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      accept = 1'b0;
      issue = 1'b0;
      update = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept = req_valid;
         end
         ST_SCAN: issue = 1'b1;
         ST_WAIT: ;
         ST_UPDATE: update = 1'b1;
         ST_DONE: load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign start = accept && (req_data.operation == OP_LOOKUP);

   always_comb begin
      hits_next = (hit_cnt == HIT_MAX) ? HIT_MAX : hit_cnt + 15'd1;
      wr_addr = scan_flags.hit ? hit_idx : (scan_flags.empty_found ? empty_idx : victim_idx);
      wr_data.tag = req_ff.requested_surface;
      wr_data.hits = scan_flags.hit ? hits_next : '0;
   end

   always_comb begin
      addr_in = addr_ff;
      valid_in = valid_ff;
      res_in = res_ff;
      if (start) begin
         addr_in = '0;
      end else if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
      if (accept && (req_data.operation == OP_CLEAR)) begin
         valid_in = '0;
         res_in = '0;
      end else if (update) begin
         valid_in[wr_addr] = 1'b1;
         res_in.hit = scan_flags.hit;
         res_in.slot_used = SLOT_W'(wr_addr);
         res_in.evicted_valid = !scan_flags.hit && !scan_flags.empty_found;
         res_in.evicted_surface = res_in.evicted_valid ? victim_tag : '0;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cmp_idx_ff <= addr_ff;
      res_ff <= res_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (load) begin
         rsp_data_ff <= res_ff;
      end
   end

   lcpe_store #(
      .ENTRIES(ENTRIES),
      .IDX_W(IDX_W)
   ) u_store (
      .clock(clock),
      .wr_en(update),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(issue),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   lcpe_scan #(
      .IDX_W(IDX_W)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .start(start),
      .cmp_vld(cmp_vld_ff),
      .cmp_idx(cmp_idx_ff),
      .ent_valid(valid_ff[cmp_idx_ff]),
      .ent(rd_data),
      .req_surface(req_ff.requested_surface),
      .prot_surface(req_ff.protected_surface),
      .flags(scan_flags),
      .hit_idx(hit_idx),
      .hit_cnt(hit_cnt),
      .empty_idx(empty_idx),
      .victim_idx(victim_idx),
      .victim_tag(victim_tag)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `LCPE_ASSERT_NEXT(a_clear_empties, accept && (req_data.operation == OP_CLEAR), valid_ff == '0)
   `LCPE_ASSERT_NOW(a_evict_only_full, update && !scan_flags.hit && !scan_flags.empty_found, &valid_ff)
   `LCPE_ASSERT_NOW(a_cmp_in_scan, cmp_vld_ff, (state_ff == ST_SCAN) || (state_ff == ST_WAIT))
   `LCPE_ASSERT_NEXT(a_miss_fills, update && !scan_flags.hit, $countones(valid_ff) >= 1)

endmodule

// ----- rtl/lcpe_store.sv -----
module lcpe_store #(
   parameter int unsigned ENTRIES = 8,
   parameter int unsigned IDX_W = 3
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  lcpe_pkg::entry_type wr_data,
   input  logic rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output lcpe_pkg::entry_type rd_data
);
   import lcpe_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lcpe_scan.sv -----
module lcpe_scan #(
   parameter int unsigned IDX_W = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic cmp_vld,
   input  logic [IDX_W-1:0] cmp_idx,
   input  logic ent_valid,
   input  lcpe_pkg::entry_type ent,
   input  logic [lcpe_pkg::TAG_W-1:0] req_surface,
   input  logic [lcpe_pkg::TAG_W-1:0] prot_surface,
   output lcpe_pkg::scan_flags_type flags,
   output logic [IDX_W-1:0] hit_idx,
   output logic [lcpe_pkg::HITS_W-1:0] hit_cnt,
   output logic [IDX_W-1:0] empty_idx,
   output logic [IDX_W-1:0] victim_idx,
   output logic [lcpe_pkg::TAG_W-1:0] victim_tag
);
   import lcpe_pkg::*;

   scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [HITS_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic [HITS_W-1:0] lowest_ff, lowest_in;
   logic [IDX_W-1:0] victim_idx_ff, victim_idx_in;
   logic [TAG_W-1:0] victim_tag_ff, victim_tag_in;
   logic match;
   logic qualify;

   // One entry is compared per cycle against the request, the protected id
   // and the lowest count seen so far.
   always_comb begin
      match = ent_valid && (ent.tag == req_surface);
      qualify = ent_valid && (ent.tag != prot_surface) && (ent.hits < lowest_ff);
      flags_in = flags_ff;
      hit_idx_in = hit_idx_ff;
      hit_cnt_in = hit_cnt_ff;
      empty_idx_in = empty_idx_ff;
      lowest_in = lowest_ff;
      victim_idx_in = victim_idx_ff;
      victim_tag_in = victim_tag_ff;
      if (start) begin
         flags_in = '0;
         lowest_in = HIT_LIMIT;
         victim_idx_in = '0;
      end else if (cmp_vld) begin
         if (match && !flags_ff.hit) begin
            flags_in.hit = 1'b1;
            hit_idx_in = cmp_idx;
            hit_cnt_in = ent.hits;
         end
         if (!ent_valid && !flags_ff.empty_found) begin
            flags_in.empty_found = 1'b1;
            empty_idx_in = cmp_idx;
         end
         if (qualify) begin
            lowest_in = ent.hits;
            victim_idx_in = cmp_idx;
         end
         // Slot 0 is the fallback victim, so its id is always captured.
         if (qualify || (cmp_idx == '0)) begin
            victim_tag_in = ent.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
      empty_idx_ff <= empty_idx_in;
      lowest_ff <= lowest_in;
      victim_idx_ff <= victim_idx_in;
      victim_tag_ff <= victim_tag_in;
   end

   assign flags = flags_ff;
   assign hit_idx = hit_idx_ff;
   assign hit_cnt = hit_cnt_ff;
   assign empty_idx = empty_idx_ff;
   assign victim_idx = victim_idx_ff;
   assign victim_tag = victim_tag_ff;

endmodule

// ----- tb/lfu_cache_checker.sv -----
`timescale 1ns / 100ps

module lfu_cache_checker #(
   parameter int unsigned SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lcpe_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lcpe_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import lcpe_pkg::*;

   logic [TAG_W-1:0]  cached_tag   [SLOTS];
   logic              cached_valid [SLOTS];
   logic [HITS_W-1:0] cached_hits  [SLOTS];
   int unsigned       cached_count;
   rsp_type           expected_rsp [$];

   initial begin
      fail_count = 0;
      pending_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         cached_tag[i] = '0;
      end
      empty_cache();
   end

   function automatic void empty_cache();
      for (int i = 0; i < SLOTS; i++) begin
         cached_valid[i] = 1'b0;
         cached_hits[i] = '0;
      end
      cached_count = 0;
   endfunction

   function automatic rsp_type predict_response(req_type item);
      rsp_type           res;
      int unsigned       victim;
      logic [HITS_W-1:0] lowest;
      bit                placed;
      res = '0;
      if (item.operation == OP_CLEAR) begin
         empty_cache();
         return res;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (cached_valid[i] && cached_tag[i] == item.requested_surface) begin
            if (cached_hits[i] != HIT_MAX) begin
               cached_hits[i] = cached_hits[i] + 1'b1;
            end
            res.hit = 1'b1;
            res.slot_used = SLOT_W'(i);
            return res;
         end
      end
      if (cached_count >= SLOTS) begin
         victim = 0;
         lowest = HIT_LIMIT;
         for (int i = 0; i < SLOTS; i++) begin
            if (cached_valid[i] && cached_tag[i] != item.protected_surface
                  && cached_hits[i] < lowest) begin
               lowest = cached_hits[i];
               victim = i;
            end
         end
         res.evicted_valid = 1'b1;
         res.evicted_surface = cached_tag[victim];
         cached_valid[victim] = 1'b0;
         cached_hits[victim] = '0;
         cached_count--;
      end
      placed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!placed && !cached_valid[i]) begin
            placed = 1'b1;
            cached_valid[i] = 1'b1;
            cached_tag[i] = item.requested_surface;
            cached_hits[i] = '0;
            cached_count++;
            res.slot_used = SLOT_W'(i);
         end
      end
      return res;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         empty_cache();
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected, expected none actual %0h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("hit", want.hit, rsp_data.hit);
               compare_field("slot_used", want.slot_used, rsp_data.slot_used);
               compare_field("evicted_valid", want.evicted_valid, rsp_data.evicted_valid);
               compare_field("evicted_surface", want.evicted_surface,
                             rsp_data.evicted_surface);
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_response(req_data));
         end
      end
      pending_count <= expected_rsp.size();
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import lcpe_pkg::*;

   localparam int unsigned CACHE_SLOTS = 8;
   localparam int unsigned POOL_SIZE = 12;
   localparam int unsigned ITEMS_PER_PHASE = 230;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   logic [TAG_W-1:0] id_pool [POOL_SIZE];

   lfu_cache_with_protected_entry_top #(
      .ENTRIES(CACHE_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   lfu_cache_checker #(
      .SLOTS(CACHE_SLOTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_request(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic lookup(input logic [TAG_W-1:0] surface, input logic [TAG_W-1:0] guard);
      req_type item;
      item.operation = OP_LOOKUP;
      item.requested_surface = surface;
      item.protected_surface = guard;
      send_request(item);
   endtask

   task automatic clear_cache(input logic [TAG_W-1:0] surface, input logic [TAG_W-1:0] guard);
      req_type item;
      item.operation = OP_CLEAR;
      item.requested_surface = surface;
      item.protected_surface = guard;
      send_request(item);
   endtask

   function automatic logic [TAG_W-1:0] pick_surface();
      if ($urandom_range(99) < 6) begin
         return TAG_W'($urandom);
      end
      if ($urandom_range(1)) begin
         return id_pool[$urandom_range(3)];
      end
      return id_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic req_type random_request();
      req_type item;
      int      roll;
      item.operation = ($urandom_range(99) < 3) ? OP_CLEAR : OP_LOOKUP;
      item.requested_surface = pick_surface();
      roll = $urandom_range(99);
      if (roll < 20) begin
         item.protected_surface = item.requested_surface;
      end else if (roll < 40) begin
         item.protected_surface = TAG_W'($urandom);
      end else begin
         item.protected_surface = id_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return item;
   endfunction

   initial begin
      int sender_mode [4];
      int receiver_mode [4];
      sender_mode = '{0, 82, 0, 13};
      receiver_mode = '{0, 0, 82, 13};

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      lookup(16'h0000, 16'hFFFF);
      lookup(16'hFFFF, 16'h0000);
      lookup(16'hFFFF, 16'hFFFF);
      for (int i = 1; i <= 6; i++) begin
         lookup(16'h1000 + TAG_W'(i), 16'h0000);
      end
      lookup(16'h0000, 16'h0000);
      lookup(16'h1001, 16'h1001);
      lookup(16'h1001, 16'hFFFF);
      lookup(16'h2000, 16'h1002);
      lookup(16'h2001, 16'h5555);
      lookup(16'h2002, 16'h0000);
      lookup(16'h2000, 16'h2000);
      clear_cache(16'hFFFF, 16'hFFFF);
      clear_cache(16'h0000, 16'h0000);
      lookup(16'hABCD, 16'hABCD);
      lookup(16'hABCD, 16'h0000);

      // Give one entry a few hits, then check that eviction passes over it.
      clear_cache(16'h1234, 16'h4321);
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         lookup(16'h3000 + TAG_W'(i), 16'h0000);
      end
      for (int i = 0; i < 3; i++) begin
         lookup(16'h3000, 16'h3001);
      end
      for (int i = 0; i < 4; i++) begin
         lookup(16'h3100 + TAG_W'(i), 16'h3001);
      end
      lookup(16'h3000, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = TAG_W'($urandom);
         end
         sender_idle_pct = sender_mode[phase];
         receiver_stall_pct = receiver_mode[phase];
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_request(random_request());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lcpe_pkg.sv
rtl/lcpe_store.sv
rtl/lcpe_scan.sv
rtl/lfu_cache_with_protected_entry_top.sv
tb/lfu_cache_checker.sv
tb/tb.sv
